// ===== rtl/lsiq_pkg.sv =====
// lsiq_pkg: shared constants, codes and types of the lockstep input queue.
// No dependencies; imported by every rtl module of the block.

package lsiq_pkg;

	// default sizing, handed down from the top level parameters
	localparam int DEF_NUM_QUEUES = 2;
	localparam int DEF_RING_SLOTS = 32;
	localparam int DEF_LEAD_LIMIT = 4;

	localparam int DATA_W       = 32;
	localparam int PRIMED_SLOTS = 4;

	localparam logic [31:0] TICK_RESET   = 32'hFFFF_FFFF;
	localparam logic [31:0] TICK_RESTART = 32'd3;

	// operation codes
	localparam logic [1:0] OP_PUT     = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// link modes
	localparam logic [1:0] MODE_LOCAL  = 2'd0;
	localparam logic [1:0] MODE_LINKED = 2'd1;

	// configuration register indexes
	localparam logic [1:0] REG_COMM_MODE      = 2'd0;
	localparam logic [1:0] REG_ACTIVE_PLAYERS = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_ADV_RD,
		ST_ADV_EMIT,
		ST_MISC
	} state_t;

	// one result item as handed from the controller to the output register
	typedef struct packed {
		logic              accepted;
		logic              player;
		logic [DATA_W-1:0] data;
		logic [31:0]       tick;
		logic              last;
	} result_t;

endpackage

// ===== rtl/lsiq_slot_ram.sv =====
// lsiq_slot_ram: single-port slot data memory, registered read.
// Depends on lsiq_pkg for the data width.

module lsiq_slot_ram
	import lsiq_pkg::*;
#(
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lsiq_ctrl.sv =====
// lsiq_ctrl: sequencer, slot valid bits, ring pointers, ticker and config registers.
// Depends on lsiq_pkg; drives the port of lsiq_slot_ram.

module lsiq_ctrl
	import lsiq_pkg::*;
#(
	parameter int NUM_QUEUES = DEF_NUM_QUEUES,
	parameter int RING_SLOTS = DEF_RING_SLOTS,
	parameter int LEAD_LIMIT = DEF_LEAD_LIMIT,
	parameter int QUEUE_W    = 1,
	parameter int SLOT_W     = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic                      player,
	input  logic [4:0]                time_slot,
	input  logic [DATA_W-1:0]         in_data,
	input  logic                      cfg_valid,
	input  logic [1:0]                cfg_index,
	input  logic [1:0]                cfg_data,
	input  logic                      out_free,
	output logic                      emit,
	output result_t                   res,
	output logic                      ram_we,
	output logic                      ram_re,
	output logic [QUEUE_W+SLOT_W-1:0] ram_addr,
	output logic [DATA_W-1:0]         ram_wdata,
	input  logic [DATA_W-1:0]         ram_rdata
);

	localparam int ADDR_W = QUEUE_W + SLOT_W;
	localparam int DEPTH  = 2**ADDR_W;

	state_t state_q, state_d;

	// captured item
	logic [1:0]        op_q;
	logic              player_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DATA_W-1:0] data_q;

	// queue state
	logic [DEPTH-1:0]  valid_q;
	logic [DEPTH-1:0]  written_q;
	logic [SLOT_W-1:0] tail_idx_q [2];
	logic [31:0]       tail0_q;
	logic [31:0]       head_q;
	logic [31:0]       ticker_q;
	logic [QUEUE_W-1:0] adv_q_q;

	logic [1:0] comm_mode_q;
	logic [1:0] active_q;

	logic [4:0]        ts_red;
	logic [ADDR_W-1:0] put_addr;
	logic [ADDR_W-1:0] adv_addr;
	logic [1:0]        n_eff;
	logic              blocked;
	logic              put_allowed;
	logic              tick_inc;
	logic              adv_last;
	logic              put_ok;
	logic              adv_clear;
	logic              adv_done;
	logic              restart_do;

	// time slot modulo ring size: at most three subtractions for a 5-bit value
	always_comb begin
		ts_red = time_slot;
		for (int i = 0; i < 3; i++) begin
			if (int'(ts_red) >= RING_SLOTS) begin
				ts_red = ts_red - 5'(RING_SLOTS);
			end
		end
	end

	assign put_addr = {QUEUE_W'(player_q), tail_idx_q[player_q]};
	assign adv_addr = {adv_q_q, slot_q};
	assign n_eff    = (int'(active_q) < NUM_QUEUES) ? active_q : 2'(NUM_QUEUES);
	assign adv_last = ((2'(adv_q_q) + 2'd1) == n_eff);

	// lead check: signed compare of tail against head plus lead limit
	assign blocked = !player_q
		&& (comm_mode_q == MODE_LOCAL || comm_mode_q == MODE_LINKED)
		&& ($signed(tail0_q) >= $signed(head_q + 32'(LEAD_LIMIT)));

	assign put_allowed = (int'(player_q) < NUM_QUEUES) && !blocked && !valid_q[put_addr];

	assign tick_inc = ((comm_mode_q == MODE_LOCAL) && (active_q < 2'd2 || player_q))
		|| ((comm_mode_q == MODE_LINKED) && player_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = (state_q != ST_IDLE);
		emit       = 1'b0;
		res        = '0;
		res.tick   = ticker_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = put_addr;
		ram_wdata  = data_q;
		put_ok     = 1'b0;
		adv_clear  = 1'b0;
		adv_done   = 1'b0;
		restart_do = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_PUT:     state_d = ST_PUT;
						OP_ADVANCE: state_d = ST_ADV_RD;
						default:    state_d = ST_MISC;
					endcase
				end
			end
			ST_PUT: begin
				if (out_free) begin
					emit         = 1'b1;
					put_ok       = put_allowed;
					ram_we       = put_allowed;
					res.accepted = put_allowed;
					res.player   = player_q;
					res.last     = 1'b1;
					res.tick     = (put_allowed && tick_inc) ? ticker_q + 32'd1 : ticker_q;
					state_d      = ST_IDLE;
				end
			end
			ST_ADV_RD: begin
				if (n_eff == 2'd0) begin
					adv_done = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					ram_re   = 1'b1;
					ram_addr = adv_addr;
					state_d  = ST_ADV_EMIT;
				end
			end
			ST_ADV_EMIT: begin
				ram_addr = adv_addr;
				if (out_free) begin
					emit       = 1'b1;
					adv_clear  = 1'b1;
					res.player = adv_q_q[0];
					// slots never written since reset or restart read as zero
					res.data   = written_q[adv_addr] ? ram_rdata : '0;
					res.last   = adv_last;
					if (adv_last) begin
						adv_done = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d  = ST_ADV_RD;
					end
				end
			end
			ST_MISC: begin
				if (out_free) begin
					emit       = 1'b1;
					restart_do = (op_q == OP_RESTART);
					res.tick   = (op_q == OP_RESTART) ? TICK_RESTART : ticker_q;
					res.last   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// captured item, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q     <= operation;
			player_q <= player;
			slot_q   <= SLOT_W'(ts_red);
			data_q   <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comm_mode_q <= 2'd0;
			active_q    <= 2'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COMM_MODE:      comm_mode_q <= cfg_data;
				REG_ACTIVE_PLAYERS: active_q    <= cfg_data;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			written_q     <= '0;
			tail_idx_q[0] <= '0;
			tail_idx_q[1] <= '0;
			tail0_q       <= '0;
			head_q        <= '0;
			ticker_q      <= TICK_RESET;
			adv_q_q       <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				adv_q_q <= '0;
			end
			if (put_ok) begin
				valid_q[put_addr]    <= 1'b1;
				written_q[put_addr]  <= 1'b1;
				tail_idx_q[player_q] <= (int'(tail_idx_q[player_q]) == RING_SLOTS - 1)
					? '0 : tail_idx_q[player_q] + SLOT_W'(1);
				if (!player_q) begin
					tail0_q <= tail0_q + 32'd1;
				end
				if (tick_inc) begin
					ticker_q <= ticker_q + 32'd1;
				end
			end
			if (adv_clear) begin
				valid_q[adv_addr] <= 1'b0;
				if (!adv_last) begin
					adv_q_q <= adv_q_q + QUEUE_W'(1);
				end
			end
			if (adv_done) begin
				head_q <= head_q + 32'd1;
			end
			if (restart_do) begin
				for (int a = 0; a < DEPTH; a++) begin
					valid_q[a] <= ((a % (2**SLOT_W)) < PRIMED_SLOTS);
				end
				written_q     <= '0;
				tail_idx_q[0] <= SLOT_W'(PRIMED_SLOTS);
				tail_idx_q[1] <= SLOT_W'(PRIMED_SLOTS);
				tail0_q       <= 32'(PRIMED_SLOTS);
				head_q        <= '0;
				ticker_q      <= TICK_RESTART;
			end
		end
	end

endmodule

// ===== rtl/lockstep_input_queue.sv =====
// lockstep_input_queue: per-player input rings; uses lsiq_pkg, lsiq_ctrl, lsiq_slot_ram.
// Put, restart, unused op: captured from idle, result emitted from the ST_PUT or ST_MISC state.
// Advance: ST_ADV_RD reads and ST_ADV_EMIT emits the slot of each active player in turn; no result with none.
// Output stalls hold the sequencer; one item at a time, paced by the single-port slot memory.
// A result waits in the output register while the next item is taken.
// Reset: valid bits and write marks cleared at once, pointers zero, ticker all ones; no sweep.

module lockstep_input_queue
	import lsiq_pkg::*;
#(
	parameter int NUM_QUEUES = DEF_NUM_QUEUES,
	parameter int RING_SLOTS = DEF_RING_SLOTS,
	parameter int LEAD_LIMIT = DEF_LEAD_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic               player,
	input  logic [4:0]         time_slot,
	input  logic [7:0]         steering,
	input  logic [7:0]         gas,
	input  logic [7:0]         brake,
	input  logic [7:0]         button_flags,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [1:0]         cfg_data,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic               out_player,
	output logic [7:0]         cur_steering,
	output logic [7:0]         cur_gas,
	output logic [7:0]         cur_brake,
	output logic [7:0]         cur_flags,
	output logic signed [31:0] tick_count,
	output logic               last
);

	// queue index needs at least one bit even with a single queue
	localparam int QUEUE_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int SLOT_W  = $clog2(RING_SLOTS);
	localparam int ADDR_W  = QUEUE_W + SLOT_W;

	logic              emit;
	result_t           res;
	result_t           res_q;
	logic              out_valid_q;
	logic              out_free;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] in_data;

	// stored word: steering in the low byte, flags in the high byte
	assign in_data = {button_flags, brake, gas, steering};

	// registers are always writable
	assign cfg_ready = 1'b1;

	// output register is free when empty or its transfer completes this cycle
	assign out_free = !out_valid_q || !out_stall;

	lsiq_ctrl #(
		.NUM_QUEUES (NUM_QUEUES),
		.RING_SLOTS (RING_SLOTS),
		.LEAD_LIMIT (LEAD_LIMIT),
		.QUEUE_W    (QUEUE_W),
		.SLOT_W     (SLOT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.player    (player),
		.time_slot (time_slot),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_free  (out_free),
		.emit      (emit),
		.res       (res),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	lsiq_slot_ram #(
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = res_q.accepted;
	assign out_player   = res_q.player;
	assign cur_steering = res_q.data[7:0];
	assign cur_gas      = res_q.data[15:8];
	assign cur_brake    = res_q.data[23:16];
	assign cur_flags    = res_q.data[31:24];
	assign tick_count   = $signed(res_q.tick);
	assign last         = res_q.last;

endmodule
